[sv/buddy_pkg.sv]
// ----------------------------------------------------------------------------
// buddy_pkg
// Shared types and codes of the buddy allocator: node kinds, result codes,
// controller states and the command/status bundles between ctrl and datapath.
// ----------------------------------------------------------------------------
package buddy_pkg;

  localparam int unsigned MaxLevelsDef = 10;
  localparam int unsigned CfgW         = 5;

  typedef enum logic [1:0] {
    KIND_ABSENT = 2'd0,
    KIND_FREE   = 2'd1,
    KIND_SPLIT  = 2'd2,
    KIND_DATA   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOSPACE   = 3'd1,
    ST_UNALIGNED = 3'd2,
    ST_BOUNDS    = 3'd3,
    ST_NOTALLOC  = 3'd4,
    ST_BADCFG    = 3'd5
  } status_e;

  typedef enum logic {
    CFG_LARGEST  = 1'b0,
    CFG_SMALLEST = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    DEC_NONE, DEC_LOAD, DEC_ONE, DEC_TWO, DEC_THREE
  } dec_e;

  typedef enum logic [1:0] {
    MEM_NONE, MEM_RD, MEM_WR
  } mem_e;

  typedef enum logic [2:0] {
    A_CLR, A_N, A_B, A_PUSH, A_PREV, A_NEXT, A_HEAD
  } addr_e;

  typedef enum logic [2:0] {
    W_CLR, W_KIND, W_SETPREV, W_PUSH, W_ULP, W_ULQ
  } wsel_e;

  typedef enum logic [1:0] {
    H_NONE, H_UNLINK, H_PUSH, H_ROOT
  } head_e;

  typedef enum logic [1:0] {
    L_HOLD, L_INC, L_DEC
  } lvl_e;

  typedef enum logic [1:0] {
    SS_ZERO, SS_END, SS_NODE
  } start_e;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DEC1, S_DEC2, S_DEC3, S_DISP,
    S_A_ENT, S_UL_P, S_UL_PW, S_UL_Q, S_UL_QW, S_UL_END,
    S_A_SPLIT, S_PUSH, S_PUSH_OW, S_PUSH_NW,
    S_F_RD, S_F_WALK, S_F_MERGE, S_F_BCHK, S_DONE
  } state_e;

  typedef struct packed {
    dec_e    dec;
    mem_e    mem;
    addr_e   addr;
    wsel_e   wsel;
    kind_e   kind;
    logic    push_flip;
    logic    ent_ld;
    head_e   head;
    lvl_e    lvl;
    logic    res_set;
    status_e st;
    start_e  ss;
  } ctl_t;

  typedef struct packed {
    logic  cfg_wr;
    logic  clr_last;
    logic  is_free;
    logic  cfg_ok;
    logic  zero_cnt;
    logic  too_big;
    logic  found;
    logic  unal;
    logic  at_end;
    logic  oob;
    kind_e rd_kind;
    logic  ent_pok;
    logic  ent_nok;
    logic  hok_lvl;
    logic  lvl_lt_tgt;
    logic  lvl_ge_deep;
    logic  lvl_zero;
    logic  out_busy;
  } sts_t;

endpackage

[sv/buddy_dp.sv]
// ----------------------------------------------------------------------------
// buddy_dp
// Datapath: config registers, request decode, node memory (kind and free
// list links per node), per-level free list heads and the result register.
// ----------------------------------------------------------------------------
module buddy_dp #(
  parameter int unsigned MAX_LEVELS = buddy_pkg::MaxLevelsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [buddy_pkg::CfgW-1:0] cfg_data_i,
  input  logic                       in_op_i,
  input  logic [31:0]                in_count_i,
  input  logic [31:0]                in_index_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [31:0]                out_start_o,
  output logic [2:0]                 out_status_o,
  input  buddy_pkg::ctl_t            ctl_i,
  output buddy_pkg::sts_t            sts_o
);
  import buddy_pkg::*;

  localparam int unsigned NW    = MAX_LEVELS;
  localparam int unsigned SW    = MAX_LEVELS;
  localparam int unsigned LW    = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int unsigned Nodes = (2 ** MAX_LEVELS) - 1;

  typedef struct packed {
    kind_e         kind;
    logic          pok;
    logic [NW-1:0] prev;
    logic          nok;
    logic [NW-1:0] next;
  } ent_t;

  function automatic logic [SW-1:0] slot_f(logic [LW-1:0] l, logic [NW-1:0] n);
    logic [SW-1:0] base;
    base = (SW'(1) << l) - SW'(1);
    return base + (n & base);
  endfunction

  logic [CfgW-1:0] lg_q, sm_q, diff;
  logic            cfg_ok;
  logic [LW-1:0]   deep;
  logic [32:0]     mask33, ms33;

  logic            op_q;
  logic [31:0]     cnt_q, inx_q, idxs_q;
  logic [32:0]     need_q;
  logic            unal_q, zero_q, big_q, end_q, oob_q, found_q;
  logic [LW-1:0]   tgt_q, p_q, lvl_q;
  logic [NW-1:0]   n_q, pnode, nm1;
  logic [LW-1:0]   log_c, tz_c, fl_c;
  logic            found_c;

  ent_t            mem_q [Nodes];
  ent_t            rd_q, ent_q, wdata;
  logic [SW-1:0]   addr, clr_q;
  logic [NW-1:0]   head_q [MAX_LEVELS];
  logic            hok_q  [MAX_LEVELS];

  logic            out_valid_q;
  logic [31:0]     out_start_q, start_c;
  status_e         out_st_q;
  logic [5:0]      shamt;

  // ---- configuration
  assign diff   = lg_q - sm_q;
  assign cfg_ok = (sm_q <= lg_q) && (diff < CfgW'(MAX_LEVELS));
  assign deep   = cfg_ok ? diff[LW-1:0] : '0;
  assign mask33 = (33'd1 << sm_q) - 33'd1;
  assign ms33   = 33'd1 << deep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lg_q <= CfgW'(9);
      sm_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_LARGEST:  lg_q <= cfg_data_i;
        CFG_SMALLEST: sm_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---- decode helpers
  always_comb begin
    nm1   = need_q[NW-1:0] - NW'(1);
    log_c = '0;
    for (int i = 0; i < NW; i++) begin
      if (nm1[i]) log_c = LW'(i + 1);
    end
    // lowest set bit gives the level of the block that starts here
    tz_c = '0;
    for (int i = NW - 1; i >= 0; i--) begin
      if (idxs_q[i]) tz_c = LW'(i);
    end
    // deepest level at or above the target that has a free node
    fl_c    = '0;
    found_c = 1'b0;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      if (LW'(i) <= tgt_q && hok_q[i]) begin
        fl_c    = LW'(i);
        found_c = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctl_i.dec)
      DEC_LOAD: begin
        op_q  <= in_op_i;
        cnt_q <= in_count_i;
        inx_q <= in_index_i;
      end
      DEC_ONE: begin
        need_q <= ({1'b0, cnt_q} + mask33) >> sm_q;
        idxs_q <= inx_q >> sm_q;
        unal_q <= |(inx_q & mask33[31:0]);
      end
      DEC_TWO: begin
        zero_q <= (cnt_q == '0);
        big_q  <= (need_q > ms33);
        tgt_q  <= deep - log_c;
        end_q  <= ({1'b0, idxs_q} == ms33);
        oob_q  <= ({1'b0, idxs_q} > ms33);
        p_q    <= tz_c;
      end
      DEC_THREE: found_q <= found_c;
      default: ;
    endcase
  end

  // ---- walk position
  always_ff @(posedge clk_i) begin
    if (ctl_i.dec == DEC_TWO && op_q) begin
      lvl_q <= (idxs_q == '0) ? '0 : deep - tz_c;
    end else if (ctl_i.dec == DEC_THREE) begin
      if (!op_q) begin
        lvl_q <= fl_c;
        n_q   <= head_q[fl_c];
      end else begin
        n_q <= idxs_q[NW-1:0] >> p_q;
      end
    end else begin
      case (ctl_i.lvl)
        L_INC: begin
          lvl_q <= lvl_q + LW'(1);
          n_q   <= n_q << 1;
        end
        L_DEC: begin
          lvl_q <= lvl_q - LW'(1);
          n_q   <= n_q >> 1;
        end
        default: ;
      endcase
    end
  end

  // ---- node memory
  assign pnode = n_q ^ NW'(ctl_i.push_flip);

  always_comb begin
    case (ctl_i.addr)
      A_CLR:   addr = clr_q;
      A_N:     addr = slot_f(lvl_q, n_q);
      A_B:     addr = slot_f(lvl_q, n_q ^ NW'(1));
      A_PUSH:  addr = slot_f(lvl_q, pnode);
      A_PREV:  addr = slot_f(lvl_q, ent_q.prev);
      A_NEXT:  addr = slot_f(lvl_q, ent_q.next);
      A_HEAD:  addr = slot_f(lvl_q, head_q[lvl_q]);
      default: addr = clr_q;
    endcase
  end

  always_comb begin
    wdata = '0;
    case (ctl_i.wsel)
      W_CLR:  wdata.kind = (clr_q == '0) ? KIND_FREE : KIND_ABSENT;
      W_KIND: wdata.kind = ctl_i.kind;
      W_SETPREV: begin
        wdata      = rd_q;
        wdata.prev = pnode;
        wdata.pok  = 1'b1;
      end
      W_PUSH: begin
        wdata.kind = KIND_FREE;
        wdata.nok  = hok_q[lvl_q];
        wdata.next = head_q[lvl_q];
      end
      W_ULP: begin
        wdata      = rd_q;
        wdata.next = ent_q.next;
        wdata.nok  = ent_q.nok;
      end
      W_ULQ: begin
        wdata      = rd_q;
        wdata.prev = ent_q.prev;
        wdata.pok  = ent_q.pok;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mem == MEM_WR) mem_q[addr] <= wdata;
    if (ctl_i.mem == MEM_RD) rd_q <= mem_q[addr];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ent_ld) ent_q <= rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cfg_we_i) begin
      clr_q <= '0;
    end else if (ctl_i.mem == MEM_WR && ctl_i.addr == A_CLR) begin
      clr_q <= clr_q + SW'(1);
    end
  end

  // ---- free list heads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
        head_q[i] <= '0;
        hok_q[i]  <= (i == 0);
      end
    end else if (cfg_we_i) begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
        head_q[i] <= '0;
        hok_q[i]  <= (i == 0);
      end
    end else begin
      case (ctl_i.head)
        H_UNLINK: begin
          head_q[lvl_q] <= ent_q.next;
          hok_q[lvl_q]  <= ent_q.nok;
        end
        H_PUSH: begin
          head_q[lvl_q] <= pnode;
          hok_q[lvl_q]  <= 1'b1;
        end
        H_ROOT: begin
          head_q[0] <= '0;
          hok_q[0]  <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // ---- result word
  assign shamt = 6'(deep) - 6'(lvl_q) + 6'(sm_q);

  always_comb begin
    case (ctl_i.ss)
      SS_END:  start_c = 32'd1 << lg_q;
      SS_NODE: start_c = 32'(n_q) << shamt;
      default: start_c = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.res_set) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.res_set) begin
      out_start_q <= start_c;
      out_st_q    <= ctl_i.st;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_start_o  = out_start_q;
  assign out_status_o = out_st_q;

  always_comb begin
    sts_o             = '0;
    sts_o.cfg_wr      = cfg_we_i;
    sts_o.clr_last    = (clr_q == SW'(Nodes - 1));
    sts_o.is_free     = op_q;
    sts_o.cfg_ok      = cfg_ok;
    sts_o.zero_cnt    = zero_q;
    sts_o.too_big     = big_q;
    sts_o.found       = found_q;
    sts_o.unal        = unal_q;
    sts_o.at_end      = end_q;
    sts_o.oob         = oob_q;
    sts_o.rd_kind     = rd_q.kind;
    sts_o.ent_pok     = ent_q.pok;
    sts_o.ent_nok     = ent_q.nok;
    sts_o.hok_lvl     = hok_q[lvl_q];
    sts_o.lvl_lt_tgt  = (lvl_q < tgt_q);
    sts_o.lvl_ge_deep = (lvl_q >= deep);
    sts_o.lvl_zero    = (lvl_q == '0);
    sts_o.out_busy    = out_valid_q && !out_ready_i;
  end

endmodule

[sv/buddy_ctrl.sv]
// ----------------------------------------------------------------------------
// buddy_ctrl
// Sequencer: memory clear, request decode, free list unlink/push, alloc
// split walk, free search and buddy merge, result handoff.
// ----------------------------------------------------------------------------
module buddy_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  buddy_pkg::sts_t sts_i,
  output buddy_pkg::ctl_t ctl_o
);
  import buddy_pkg::*;

  state_e  state_q, state_d;
  status_e st_q, st_d;
  start_e  ss_q, ss_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      st_q    <= ST_OK;
      ss_q    <= SS_ZERO;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
      ss_q    <= ss_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    st_d       = st_q;
    ss_d       = ss_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    ctl_o.push_flip = !sts_i.is_free;

    case (state_q)
      S_CLEAR: begin
        ctl_o.mem  = MEM_WR;
        ctl_o.addr = A_CLR;
        ctl_o.wsel = W_CLR;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.dec = DEC_LOAD;
          state_d   = S_DEC1;
        end
      end
      S_DEC1: begin
        ctl_o.dec = DEC_ONE;
        state_d   = S_DEC2;
      end
      S_DEC2: begin
        ctl_o.dec = DEC_TWO;
        state_d   = S_DEC3;
      end
      S_DEC3: begin
        ctl_o.dec = DEC_THREE;
        state_d   = S_DISP;
      end
      S_DISP: begin
        st_d    = ST_OK;
        ss_d    = SS_ZERO;
        state_d = S_DONE;
        if (!sts_i.cfg_ok) begin
          st_d = ST_BADCFG;
        end else if (!sts_i.is_free) begin
          if (sts_i.zero_cnt) begin
            ss_d = SS_END;
          end else if (sts_i.too_big || !sts_i.found) begin
            st_d = ST_NOSPACE;
          end else begin
            ctl_o.mem  = MEM_RD;
            ctl_o.addr = A_N;
            state_d    = S_A_ENT;
          end
        end else begin
          if (sts_i.unal) begin
            st_d = ST_UNALIGNED;
          end else if (sts_i.at_end) begin
            st_d = ST_OK;
          end else if (sts_i.oob) begin
            st_d = ST_BOUNDS;
          end else begin
            ctl_o.mem  = MEM_RD;
            ctl_o.addr = A_N;
            state_d    = S_F_WALK;
          end
        end
      end
      S_A_ENT: begin
        ctl_o.ent_ld = 1'b1;
        state_d      = S_UL_P;
      end
      // unlink the node held in the entry register from its level list
      S_UL_P: begin
        if (sts_i.ent_pok) begin
          ctl_o.mem  = MEM_RD;
          ctl_o.addr = A_PREV;
          state_d    = S_UL_PW;
        end else begin
          ctl_o.head = H_UNLINK;
          state_d    = S_UL_Q;
        end
      end
      S_UL_PW: begin
        ctl_o.mem  = MEM_WR;
        ctl_o.addr = A_PREV;
        ctl_o.wsel = W_ULP;
        state_d    = S_UL_Q;
      end
      S_UL_Q: begin
        if (sts_i.ent_nok) begin
          ctl_o.mem  = MEM_RD;
          ctl_o.addr = A_NEXT;
          state_d    = S_UL_QW;
        end else begin
          state_d = S_UL_END;
        end
      end
      S_UL_QW: begin
        ctl_o.mem  = MEM_WR;
        ctl_o.addr = A_NEXT;
        ctl_o.wsel = W_ULQ;
        state_d    = S_UL_END;
      end
      S_UL_END: begin
        if (!sts_i.is_free) begin
          state_d = S_A_SPLIT;
        end else begin
          // buddy merged away, move up one level
          ctl_o.mem  = MEM_WR;
          ctl_o.addr = A_B;
          ctl_o.wsel = W_KIND;
          ctl_o.kind = KIND_ABSENT;
          ctl_o.lvl  = L_DEC;
          state_d    = S_F_MERGE;
        end
      end
      S_A_SPLIT: begin
        ctl_o.mem  = MEM_WR;
        ctl_o.addr = A_N;
        ctl_o.wsel = W_KIND;
        if (sts_i.lvl_lt_tgt) begin
          ctl_o.kind = KIND_SPLIT;
          ctl_o.lvl  = L_INC;
          state_d    = S_PUSH;
        end else begin
          ctl_o.kind = KIND_DATA;
          st_d       = ST_OK;
          ss_d       = SS_NODE;
          state_d    = S_DONE;
        end
      end
      // push onto the level list: right child on alloc, the node on free
      S_PUSH: begin
        if (sts_i.hok_lvl) begin
          ctl_o.mem  = MEM_RD;
          ctl_o.addr = A_HEAD;
          state_d    = S_PUSH_OW;
        end else begin
          state_d = S_PUSH_NW;
        end
      end
      S_PUSH_OW: begin
        ctl_o.mem  = MEM_WR;
        ctl_o.addr = A_HEAD;
        ctl_o.wsel = W_SETPREV;
        state_d    = S_PUSH_NW;
      end
      S_PUSH_NW: begin
        ctl_o.mem  = MEM_WR;
        ctl_o.addr = A_PUSH;
        ctl_o.wsel = W_PUSH;
        ctl_o.head = H_PUSH;
        if (sts_i.is_free) begin
          st_d    = ST_OK;
          ss_d    = SS_ZERO;
          state_d = S_DONE;
        end else begin
          state_d = S_A_SPLIT;
        end
      end
      S_F_RD: begin
        ctl_o.mem  = MEM_RD;
        ctl_o.addr = A_N;
        state_d    = S_F_WALK;
      end
      S_F_WALK: begin
        if (sts_i.rd_kind == KIND_DATA) begin
          state_d = S_F_MERGE;
        end else if (sts_i.rd_kind != KIND_SPLIT || sts_i.lvl_ge_deep) begin
          st_d    = ST_NOTALLOC;
          ss_d    = SS_ZERO;
          state_d = S_DONE;
        end else begin
          ctl_o.lvl = L_INC;
          state_d   = S_F_RD;
        end
      end
      S_F_MERGE: begin
        if (sts_i.lvl_zero) begin
          ctl_o.mem  = MEM_WR;
          ctl_o.addr = A_N;
          ctl_o.wsel = W_KIND;
          ctl_o.kind = KIND_FREE;
          ctl_o.head = H_ROOT;
          st_d       = ST_OK;
          ss_d       = SS_ZERO;
          state_d    = S_DONE;
        end else begin
          ctl_o.mem  = MEM_RD;
          ctl_o.addr = A_B;
          state_d    = S_F_BCHK;
        end
      end
      S_F_BCHK: begin
        if (sts_i.rd_kind != KIND_FREE) begin
          state_d = S_PUSH;
        end else begin
          ctl_o.ent_ld = 1'b1;
          ctl_o.mem    = MEM_WR;
          ctl_o.addr   = A_N;
          ctl_o.wsel   = W_KIND;
          ctl_o.kind   = KIND_ABSENT;
          state_d      = S_UL_P;
        end
      end
      S_DONE: begin
        ctl_o.st = st_q;
        ctl_o.ss = ss_q;
        if (!sts_i.out_busy) begin
          ctl_o.res_set = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase

    // any config write rebuilds the tree
    if (sts_i.cfg_wr) state_d = S_CLEAR;
  end

endmodule

[sv/buddy_allocator.sv]
// ----------------------------------------------------------------------------
// buddy_allocator
// Binary buddy allocator with per-level free lists, stream request/result.
// ----------------------------------------------------------------------------
// One request word in, one result word out. Every request is accepted,
// decoded and dispatched, and ends with the result handoff. The node memory
// is single ported, one access per cycle, so the walks go level by level: a
// free reads one node per level on its way down to its data node, an alloc
// marks the node split and pushes the right child for each level it splits,
// and a free merge checks the buddy, unlinks it from its level list and moves
// up one level. After reset and after every config write all 2^MAX_LEVELS - 1
// nodes of the node memory are cleared, and no request is taken until that is
// done. A finished result waits in the output register while the next request
// is taken.
module buddy_allocator #(
  parameter int unsigned MAX_LEVELS = buddy_pkg::MaxLevelsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [buddy_pkg::CfgW-1:0] cfg_data_i,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [63:0]                s_axis_tdata,  // count[31:0], index[63:32]
  input  logic                       s_axis_tuser,  // op (0 alloc, 1 free)
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [31:0]                m_axis_tdata,  // start_index[31:0]
  output logic [2:0]                 m_axis_tuser   // status[2:0]
);
  import buddy_pkg::*;

  ctl_t ctl;
  sts_t sts;

  buddy_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  buddy_dp #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_op_i      (s_axis_tuser),
    .in_count_i   (s_axis_tdata[31:0]),
    .in_index_i   (s_axis_tdata[63:32]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_start_o  (m_axis_tdata),
    .out_status_o (m_axis_tuser),
    .ctl_i        (ctl),
    .sts_o        (sts)
  );

  // a new result never overwrites a word still waiting downstream
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.res_set |-> !sts.out_busy)
    else $error("result written over pending word");

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request taken while busy");

  // error results carry a zero start index
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0))
    else $error("nonzero start on error");

endmodule
